// ===== src/three_level_ready_queue_scheduler_defines.svh =====
// Assertion macros shared by the scheduler modules
`ifndef THREE_LEVEL_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define THREE_LEVEL_READY_QUEUE_SCHEDULER_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define TLQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Implication checked in the cycle after the antecedent
`define TLQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== src/tlq_pkg.sv =====
package tlq_pkg;

  localparam int unsigned PRI_W   = 8;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned EL_W    = 10;
  // field widths of the word format
  localparam int unsigned BURST_W = 16;
  localparam int unsigned WAIT_W  = 16;

  typedef enum logic [1:0] {
    KIND_ENQ   = 2'd0,
    KIND_DISP  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_AGING = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_L1_FLOOR  = 3'd0,
    CFG_L2_FLOOR  = 3'd1,
    CFG_AGE_THR   = 3'd2,
    CFG_AGE_STEP  = 3'd3,
    CFG_PRI_CAP   = 3'd4,
    CFG_RR_QUANT  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_OUT
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // load the word and clear scan scratch
    logic scan;    // process the slot under the scan pointer
    logic finish;  // commit and build the result
  } tlq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } tlq_stat_t;

  function automatic logic [1:0] classify(input logic [PRI_W-1:0] pr,
                                          input logic [PRI_W-1:0] f1,
                                          input logic [PRI_W-1:0] f2);
    logic [1:0] lv;
    if (pr >= f1) lv = 2'd1;
    else if (pr >= f2) lv = 2'd2;
    else lv = 2'd3;
    return lv;
  endfunction

endpackage

// ===== src/tlq_if.sv =====
interface tlq_in_if;
  import tlq_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [ID_W-1:0]     task_id;
  logic [PRI_W-1:0]    task_priority;
  logic [BURST_W-1:0]  task_burst;
  logic [EL_W-1:0]     elapsed_ticks;
  modport source (output valid, kind, task_id, task_priority, task_burst, elapsed_ticks,
                  input ready);
  modport sink (input valid, kind, task_id, task_priority, task_burst, elapsed_ticks,
                output ready);
endinterface

interface tlq_out_if;
  import tlq_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [ID_W-1:0]     chosen_id;
  logic [1:0]          chosen_level;
  logic [PRI_W-1:0]    chosen_priority;
  logic [BURST_W-1:0]  chosen_burst;
  logic                preempt;
  logic                rr_expired;
  modport source (output valid, status, chosen_id, chosen_level, chosen_priority,
                  chosen_burst, preempt, rr_expired, input ready);
  modport sink (input valid, status, chosen_id, chosen_level, chosen_priority,
                chosen_burst, preempt, rr_expired, output ready);
endinterface

// ===== src/tlq_ctrl.sv =====
module tlq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tlq_pkg::tlq_stat_t  stat,
  output tlq_pkg::tlq_cmd_t   cmd
);
  import tlq_pkg::*;

  fsm_state_t state_r, state_nxt;

  // hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // sequence one word: load, walk the slots, commit, present the result
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`include "three_level_ready_queue_scheduler_defines.svh"
  `TLQ_ASSERT_NEXT(a_start_scans, cmd.start, state_r == S_SCAN)
  `TLQ_ASSERT_IMPL(a_no_accept_busy, state_r != S_IDLE, !in_ready)
  `TLQ_ASSERT_NEXT(a_finish_outputs, cmd.finish, out_valid)
endmodule

// ===== src/tlq_dp.sv =====
module tlq_dp #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlq_pkg::tlq_cmd_t            cmd,
  output tlq_pkg::tlq_stat_t           stat,
  input  logic                         cfg_we,
  input  logic [tlq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlq_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [1:0]                   in_kind,
  input  logic [tlq_pkg::ID_W-1:0]     in_task_id,
  input  logic [tlq_pkg::PRI_W-1:0]    in_task_priority,
  input  logic [tlq_pkg::BURST_W-1:0]  in_task_burst,
  input  logic [tlq_pkg::EL_W-1:0]     in_elapsed_ticks,
  output logic [1:0]                   out_status,
  output logic [tlq_pkg::ID_W-1:0]     out_chosen_id,
  output logic [1:0]                   out_chosen_level,
  output logic [tlq_pkg::PRI_W-1:0]    out_chosen_priority,
  output logic [tlq_pkg::BURST_W-1:0]  out_chosen_burst,
  output logic                         out_preempt,
  output logic                         out_rr_expired
);
  import tlq_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  // configuration registers
  logic [PRI_W-1:0] l1_floor_r, l2_floor_r, age_step_r, pri_cap_r;
  logic [15:0]      age_thr_r, rr_quant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_floor_r <= 8'd100;
      l2_floor_r <= 8'd50;
      age_thr_r  <= 16'd400;
      age_step_r <= 8'd10;
      pri_cap_r  <= 8'd149;
      rr_quant_r <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_L1_FLOOR: l1_floor_r <= cfg_wdata[PRI_W-1:0];
        CFG_L2_FLOOR: l2_floor_r <= cfg_wdata[PRI_W-1:0];
        CFG_AGE_THR:  age_thr_r  <= cfg_wdata;
        CFG_AGE_STEP: age_step_r <= cfg_wdata[PRI_W-1:0];
        CFG_PRI_CAP:  pri_cap_r  <= cfg_wdata[PRI_W-1:0];
        CFG_RR_QUANT: rr_quant_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // slot store: valid bits in flops, payload in registers
  logic [SLOTS-1:0]     vld_r;
  logic [ID_W-1:0]      sid_r  [SLOTS];
  logic [PRI_W-1:0]     spri_r [SLOTS];
  logic [TIME_BITS-1:0] sbur_r [SLOTS];
  logic [TIME_BITS-1:0] swait_r[SLOTS];
  logic [1:0]           slev_r [SLOTS];
  logic [TIME_BITS-1:0] sarr_r [SLOTS];

  logic [TIME_BITS-1:0] arr_ctr_r;
  logic                 cur_vld_r;
  logic [ID_W-1:0]      cur_id_r;
  logic [1:0]           cur_lev_r;
  logic [TIME_BITS-1:0] cur_bur_r, cur_run_r, cur_rr_r;

  // word latched at start
  logic [1:0]           kind_r;
  logic [ID_W-1:0]      tid_r;
  logic [PRI_W-1:0]     tpri_r;
  logic [TIME_BITS-1:0] tbur_r;
  logic [EL_W-1:0]      el_r;

  // scan scratch
  logic [IW-1:0] ptr_r;
  logic          best_vld_r;
  logic [IW-1:0] best_r;
  logic [1:0]    best_lev_r;
  logic          free_vld_r;
  logic [IW-1:0] free_r;
  logic          pre_r;

  // result registers
  logic [1:0]       res_status_r, res_lev_r;
  logic [ID_W-1:0]  res_id_r;
  logic [PRI_W-1:0] res_pri_r;
  logic [BURST_W-1:0] res_bur_r;
  logic             res_pre_r, res_exp_r;

  assign stat.scan_last = (ptr_r == IW'(SLOTS - 1));

  // saturating add of the elapsed ticks
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [EL_W-1:0] b);
    logic [32:0] s;
    s = 33'(a) + 33'(b);
    return (s > 33'(TMAX)) ? TMAX : s[TIME_BITS-1:0];
  endfunction

  // per-slot scan terms
  logic [1:0]           p_lev;
  logic                 p_better;
  logic [PRI_W:0]       np_sum;
  logic [PRI_W-1:0]     np;
  logic [1:0]           nl;
  logic                 p_age;
  logic [BURST_W:0]     tbur_ext;

  always_comb begin
    p_lev = slev_r[ptr_r];
    // dispatch: is this slot ahead of the current best
    if (!vld_r[ptr_r]) p_better = 1'b0;
    else if (!best_vld_r || p_lev < best_lev_r) p_better = 1'b1;
    else if (p_lev > best_lev_r) p_better = 1'b0;
    else if (p_lev == 2'd1 && sbur_r[ptr_r] != sbur_r[best_r])
      p_better = sbur_r[ptr_r] < sbur_r[best_r];
    else if (p_lev == 2'd2 && sid_r[ptr_r] != sid_r[best_r])
      p_better = sid_r[ptr_r] < sid_r[best_r];
    else p_better = sarr_r[ptr_r] < sarr_r[best_r];
    // aging terms
    np_sum = {1'b0, spri_r[ptr_r]} + {1'b0, age_step_r};
    np = (np_sum > {1'b0, pri_cap_r}) ? pri_cap_r : np_sum[PRI_W-1:0];
    nl = classify(np, l1_floor_r, l2_floor_r);
    p_age = vld_r[ptr_r] && (32'(swait_r[ptr_r]) >= 32'(age_thr_r));
    tbur_ext = {1'b0, in_task_burst};
  end

  logic [TIME_BITS-1:0] bur_sat;
  assign bur_sat = (tbur_ext > (BURST_W+1)'(TMAX)) ? TMAX : TIME_BITS'(in_task_burst);

  logic [1:0]           enq_lev;
  logic [TIME_BITS-1:0] rr_new;
  assign enq_lev = classify(tpri_r, l1_floor_r, l2_floor_r);
  assign rr_new  = sat_add(cur_rr_r, el_r);

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      arr_ctr_r <= '0;
      cur_vld_r <= 1'b0;
      cur_id_r  <= '0;
      cur_lev_r <= '0;
      cur_bur_r <= '0;
      cur_run_r <= '0;
      cur_rr_r  <= '0;
      ptr_r     <= '0;
    end else begin
      if (cmd.start) ptr_r <= '0;
      else if (cmd.scan) ptr_r <= ptr_r + 1'b1;
      if (cmd.scan && kind_r == KIND_AGING && p_age && nl < p_lev)
        arr_ctr_r <= arr_ctr_r + 1'b1;
      if (cmd.finish) begin
        case (kind_t'(kind_r))
          KIND_ENQ: if (free_vld_r) begin
            vld_r[free_r] <= 1'b1;
            arr_ctr_r <= arr_ctr_r + 1'b1;
          end
          KIND_DISP: if (best_vld_r) begin
            vld_r[best_r] <= 1'b0;
            cur_vld_r <= 1'b1;
            cur_id_r  <= sid_r[best_r];
            cur_lev_r <= slev_r[best_r];
            cur_bur_r <= sbur_r[best_r];
            cur_run_r <= '0;
            cur_rr_r  <= '0;
          end
          KIND_TICK: if (cur_vld_r) begin
            cur_run_r <= sat_add(cur_run_r, el_r);
            if (cur_lev_r == 2'd3) cur_rr_r <= rr_new;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers: latched word, scan scratch, slot fields, result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r <= in_kind;
      tid_r  <= in_task_id;
      tpri_r <= in_task_priority;
      tbur_r <= bur_sat;
      el_r   <= in_elapsed_ticks;
      best_vld_r <= 1'b0;
      best_r     <= '0;
      best_lev_r <= '0;
      free_vld_r <= 1'b0;
      free_r     <= '0;
      pre_r      <= 1'b0;
    end
    if (cmd.scan) begin
      case (kind_t'(kind_r))
        KIND_ENQ: if (!vld_r[ptr_r] && !free_vld_r) begin
          free_vld_r <= 1'b1;
          free_r     <= ptr_r;
        end
        KIND_DISP: if (p_better) begin
          best_vld_r <= 1'b1;
          best_r     <= ptr_r;
          best_lev_r <= p_lev;
        end
        KIND_TICK: if (vld_r[ptr_r]) swait_r[ptr_r] <= sat_add(swait_r[ptr_r], el_r);
        KIND_AGING: if (p_age) begin
          spri_r[ptr_r]  <= np;
          swait_r[ptr_r] <= '0;
          if (nl < p_lev) begin
            slev_r[ptr_r] <= nl;
            sarr_r[ptr_r] <= arr_ctr_r;
            if (nl == 2'd1 && cur_vld_r && cur_bur_r > sbur_r[ptr_r]) pre_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.finish) begin
      res_status_r <= ST_OK;
      res_id_r     <= '0;
      res_lev_r    <= '0;
      res_pri_r    <= '0;
      res_bur_r    <= '0;
      res_pre_r    <= 1'b0;
      res_exp_r    <= 1'b0;
      case (kind_t'(kind_r))
        KIND_ENQ: begin
          if (!free_vld_r) res_status_r <= ST_FULL;
          else begin
            sid_r[free_r]   <= tid_r;
            spri_r[free_r]  <= tpri_r;
            sbur_r[free_r]  <= tbur_r;
            swait_r[free_r] <= '0;
            slev_r[free_r]  <= enq_lev;
            sarr_r[free_r]  <= arr_ctr_r;
            res_lev_r <= enq_lev;
            res_pre_r <= (enq_lev == 2'd1) && cur_vld_r && (cur_bur_r > tbur_r);
          end
        end
        KIND_DISP: begin
          if (!best_vld_r) res_status_r <= ST_EMPTY;
          else begin
            res_id_r  <= sid_r[best_r];
            res_lev_r <= slev_r[best_r];
            res_pri_r <= spri_r[best_r];
            res_bur_r <= BURST_W'(sbur_r[best_r]);
          end
        end
        KIND_TICK: res_exp_r <= cur_vld_r && (cur_lev_r == 2'd3) &&
                                (32'(rr_new) >= 32'(rr_quant_r));
        default: res_pre_r <= pre_r;
      endcase
    end
  end

  assign out_status          = res_status_r;
  assign out_chosen_id       = res_id_r;
  assign out_chosen_level    = res_lev_r;
  assign out_chosen_priority = res_pri_r;
  assign out_chosen_burst    = res_bur_r;
  assign out_preempt         = res_pre_r;
  assign out_rr_expired      = res_exp_r;

  // commit strobes watched by the checks
  logic disp_commit, enq_commit;
  assign disp_commit = cmd.finish && kind_r == KIND_DISP && best_vld_r;
  assign enq_commit  = cmd.finish && kind_r == KIND_ENQ && free_vld_r;

`include "three_level_ready_queue_scheduler_defines.svh"
  `TLQ_ASSERT_NEXT(a_disp_clears, disp_commit, cur_vld_r && !vld_r[$past(best_r)])
  `TLQ_ASSERT_NEXT(a_enq_sets, enq_commit, vld_r[$past(free_r)])
  `TLQ_ASSERT_IMPL(a_best_valid, cmd.scan && best_vld_r, vld_r[best_r])
endmodule

// ===== src/three_level_ready_queue_scheduler.sv =====
// Channel  | Direction | Handshake       | Word fields
// in_      | sink      | valid / ready   | kind, task_id, task_priority, task_burst, elapsed_ticks
// out_     | source    | valid / ready   | status, chosen_id, chosen_level, chosen_priority,
//          |           |                 | chosen_burst, preempt, rr_expired
// cfg_     | write     | we              | index, wdata
// Each word is accepted, then the store is walked one slot at a time, then the word is committed,
// then the result waits in the output register until taken.
// The slot walk sets the rate for every kind of word.
// Reset is synchronous on rst_n; it empties the store and clears the current task.
// in_ready is low from acceptance until the result is taken.
module three_level_ready_queue_scheduler #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tlq_in_if.sink                        in_ch,
  tlq_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tlq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlq_pkg::CFG_W-1:0]     cfg_wdata
);
  import tlq_pkg::*;

  tlq_cmd_t  cmd;
  tlq_stat_t stat;

  tlq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlq_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_kind             (in_ch.kind),
    .in_task_id          (in_ch.task_id),
    .in_task_priority    (in_ch.task_priority),
    .in_task_burst       (in_ch.task_burst),
    .in_elapsed_ticks    (in_ch.elapsed_ticks),
    .out_status          (out_ch.status),
    .out_chosen_id       (out_ch.chosen_id),
    .out_chosen_level    (out_ch.chosen_level),
    .out_chosen_priority (out_ch.chosen_priority),
    .out_chosen_burst    (out_ch.chosen_burst),
    .out_preempt         (out_ch.preempt),
    .out_rr_expired      (out_ch.rr_expired)
  );
endmodule

// ===== bench/tb_three_level_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps

module tb_three_level_ready_queue_scheduler;
  import tlq_pkg::*;

  localparam int NSLOT = 16;

  typedef struct packed {
    kind_t                kind;
    logic [ID_W-1:0]      id;
    logic [PRI_W-1:0]     pri;
    logic [BURST_W-1:0]   burst;
    logic [EL_W-1:0]      el;
  } task_word_t;

  typedef struct packed {
    status_t              status;
    logic [ID_W-1:0]      id;
    logic [1:0]           level;
    logic [PRI_W-1:0]     pri;
    logic [BURST_W-1:0]   burst;
    logic                 preempt;
    logic                 expired;
  } sched_word_t;

  typedef struct {
    kind_t                kind;
    logic [ID_W-1:0]      id;
    logic [PRI_W-1:0]     pri;
    logic [BURST_W-1:0]   burst;
    logic [EL_W-1:0]      el;
    int                   rep;
    bit                   fixed;
    status_t              exp_status;
    logic [1:0]           exp_level;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  tlq_in_if  in_ch();
  tlq_out_if out_ch();

  three_level_ready_queue_scheduler i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // scheduler mirror: ready store, current task, registers
  bit               m_valid [NSLOT];
  logic [7:0]       m_id    [NSLOT];
  logic [7:0]       m_pri   [NSLOT];
  logic [15:0]      m_burst [NSLOT];
  logic [15:0]      m_wait  [NSLOT];
  logic [1:0]       m_level [NSLOT];
  logic [15:0]      m_stamp [NSLOT];
  logic [15:0]      next_stamp;
  bit               cur_valid;
  logic [1:0]       cur_level;
  logic [15:0]      cur_burst, cur_run, cur_rr;
  logic [7:0]       r_l1_floor, r_l2_floor, r_step, r_cap;
  logic [15:0]      r_threshold, r_quantum;

  sched_word_t expected_words[$];
  int errors = 0;
  int accepted = 0;
  bit held_once = 0;
  int hold_cnt = 0;

  // clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [1:0] level_for(logic [7:0] pr);
    if (pr >= r_l1_floor) return 2'd1;
    if (pr >= r_l2_floor) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [9:0] b);
    logic [16:0] s;
    s = {1'b0, a} + 17'(b);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // true when slot a goes before slot b within level lv
  function automatic bit goes_first(int a, int b, logic [1:0] lv);
    if (lv == 2'd1 && m_burst[a] != m_burst[b]) return m_burst[a] < m_burst[b];
    if (lv == 2'd2 && m_id[a] != m_id[b]) return m_id[a] < m_id[b];
    return m_stamp[a] < m_stamp[b];
  endfunction

  function automatic sched_word_t schedule_step(task_word_t w);
    sched_word_t r;
    int slot;
    logic [8:0] np;
    logic [1:0] nl;
    r = '0;
    r.status = ST_OK;
    slot = -1;
    case (w.kind)
      KIND_ENQ: begin
        for (int i = 0; i < NSLOT; i++)
          if (!m_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          m_valid[slot] = 1;
          m_id[slot] = w.id;
          m_pri[slot] = w.pri;
          m_burst[slot] = w.burst;
          m_wait[slot] = '0;
          m_level[slot] = level_for(w.pri);
          m_stamp[slot] = next_stamp;
          next_stamp++;
          r.level = m_level[slot];
          r.preempt = (r.level == 2'd1) && cur_valid && (cur_burst > w.burst);
        end
      end
      KIND_DISP: begin
        for (int lv = 1; lv <= 3 && slot < 0; lv++)
          for (int i = 0; i < NSLOT; i++)
            if (m_valid[i] && m_level[i] == lv &&
                (slot < 0 || goes_first(i, slot, 2'(lv)))) slot = i;
        if (slot < 0) begin
          r.status = ST_EMPTY;
        end else begin
          m_valid[slot] = 0;
          cur_valid = 1;
          cur_level = m_level[slot];
          cur_burst = m_burst[slot];
          cur_run = '0;
          cur_rr = '0;
          r.id = m_id[slot];
          r.level = m_level[slot];
          r.pri = m_pri[slot];
          r.burst = m_burst[slot];
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < NSLOT; i++)
          if (m_valid[i]) m_wait[i] = sat_add(m_wait[i], w.el);
        if (cur_valid) begin
          if (cur_level == 2'd3) cur_rr = sat_add(cur_rr, w.el);
          cur_run = sat_add(cur_run, w.el);
          r.expired = (cur_level == 2'd3) && (cur_rr >= r_quantum);
        end
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (m_valid[i] && m_wait[i] >= r_threshold) begin
            np = {1'b0, m_pri[i]} + {1'b0, r_step};
            if (np > {1'b0, r_cap}) np = {1'b0, r_cap};
            m_pri[i] = np[7:0];
            m_wait[i] = '0;
            nl = level_for(np[7:0]);
            if (nl < m_level[i]) begin
              m_level[i] = nl;
              m_stamp[i] = next_stamp;
              next_stamp++;
              if (nl == 2'd1 && cur_valid && cur_burst > m_burst[i]) r.preempt = 1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report(string field, longint e, longint a);
    $display("%0t mismatch %s: expected %0d actual %0d", $time, field, e, a);
    errors++;
  endtask

  // check each result word against the oldest expectation
  always @(posedge clk) begin
    sched_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected result word, expected none, actual status %0d",
                 $time, out_ch.status);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_ch.status !== e.status) report("status", e.status, out_ch.status);
        if (out_ch.chosen_id !== e.id) report("chosen_id", e.id, out_ch.chosen_id);
        if (out_ch.chosen_level !== e.level)
          report("chosen_level", e.level, out_ch.chosen_level);
        if (out_ch.chosen_priority !== e.pri)
          report("chosen_priority", e.pri, out_ch.chosen_priority);
        if (out_ch.chosen_burst !== e.burst)
          report("chosen_burst", e.burst, out_ch.chosen_burst);
        if (out_ch.preempt !== e.preempt) report("preempt", e.preempt, out_ch.preempt);
        if (out_ch.rr_expired !== e.expired)
          report("rr_expired", e.expired, out_ch.rr_expired);
      end
    end
  end

  function automatic bit quiet_stretch();
    return accepted >= 900 && accepted < 1100;
  endfunction

  // result side: random stalls, one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (!held_once && accepted == 400) begin
      held_once <= 1;
      hold_cnt <= 300;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_stretch() || ($urandom_range(99) >= 30);
    end
  end

  // offer one word, hold it until taken, then advance the mirror
  task automatic send_word(task_word_t w, bit fixed, status_t st, logic [1:0] lv);
    sched_word_t r;
    while (!quiet_stretch() && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= w.kind;
    in_ch.task_id <= w.id;
    in_ch.task_priority <= w.pri;
    in_ch.task_burst <= w.burst;
    in_ch.elapsed_ticks <= w.el;
    do @(posedge clk); while (!in_ch.ready);
    r = schedule_step(w);
    if (fixed) begin
      r = '0;
      r.status = st;
      r.level = lv;
    end
    expected_words.push_back(r);
    accepted++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (NSLOT + 8) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] l1, logic [7:0] l2, logic [15:0] thr,
                            logic [7:0] stp, logic [7:0] cap, logic [15:0] q);
    logic [15:0] vals [6];
    vals = '{16'(l1), 16'(l2), thr, 16'(stp), 16'(cap), q};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    r_l1_floor = l1; r_l2_floor = l2; r_threshold = thr;
    r_step = stp; r_cap = cap; r_quantum = q;
  endtask

  function automatic task_word_t random_word();
    task_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.kind = pick < 38 ? KIND_ENQ : pick < 62 ? KIND_DISP : pick < 85 ? KIND_TICK : KIND_AGING;
    w.id = 8'($urandom);
    w.pri = 8'($urandom_range(149));
    case ($urandom_range(3))
      0: w.burst = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1: w.burst = 16'($urandom_range(63));
      default: w.burst = 16'($urandom);
    endcase
    w.el = $urandom_range(3) == 0 ? 10'h3FF : 10'($urandom_range(1023));
    return w;
  endfunction

  stim_row_t rows [] = '{
    '{KIND_DISP,  8'd0,   8'd0,   16'd0,     10'd0,    1, 1, ST_EMPTY, 2'd0},
    '{KIND_TICK,  8'd0,   8'd0,   16'd0,     10'd1023, 1, 1, ST_OK,    2'd0},
    '{KIND_AGING, 8'd0,   8'd0,   16'd0,     10'd0,    1, 1, ST_OK,    2'd0},
    '{KIND_ENQ,   8'd0,   8'd0,   16'd0,     10'd0,    1, 1, ST_OK,    2'd3},
    '{KIND_ENQ,   8'd255, 8'd149, 16'hFFFF,  10'd0,    1, 1, ST_OK,    2'd1},
    '{KIND_ENQ,   8'd12,  8'd50,  16'd40,    10'd0,    1, 1, ST_OK,    2'd2},
    '{KIND_ENQ,   8'd13,  8'd49,  16'd41,    10'd0,    1, 1, ST_OK,    2'd3},
    '{KIND_ENQ,   8'd14,  8'd99,  16'd42,    10'd0,    1, 1, ST_OK,    2'd2},
    '{KIND_ENQ,   8'd15,  8'd100, 16'd5,     10'd0,    1, 1, ST_OK,    2'd1},
    '{KIND_DISP,  8'd0,   8'd0,   16'd0,     10'd0,    1, 0, ST_OK,    2'd0},
    '{KIND_ENQ,   8'd16,  8'd120, 16'd3,     10'd0,    1, 0, ST_OK,    2'd0},
    '{KIND_ENQ,   8'd7,   8'd70,  16'd300,   10'd0,   10, 0, ST_OK,    2'd0},
    '{KIND_ENQ,   8'd99,  8'd140, 16'd1,     10'd0,    1, 1, ST_FULL,  2'd0},
    '{KIND_TICK,  8'd0,   8'd0,   16'd0,     10'd1023, 1, 0, ST_OK,    2'd0},
    '{KIND_AGING, 8'd0,   8'd0,   16'd0,     10'd0,    1, 0, ST_OK,    2'd0},
    '{KIND_TICK,  8'd0,   8'd0,   16'd0,     10'd500,  1, 0, ST_OK,    2'd0},
    '{KIND_AGING, 8'd0,   8'd0,   16'd0,     10'd0,    1, 0, ST_OK,    2'd0},
    '{KIND_DISP,  8'd0,   8'd0,   16'd0,     10'd0,   17, 0, ST_OK,    2'd0},
    '{KIND_TICK,  8'd0,   8'd0,   16'd0,     10'd1023,70, 0, ST_OK,    2'd0}
  };

  initial begin
    task_word_t w;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ENQ;
    in_ch.task_id = '0;
    in_ch.task_priority = '0;
    in_ch.task_burst = '0;
    in_ch.elapsed_ticks = '0;
    for (int i = 0; i < NSLOT; i++) m_valid[i] = 0;
    next_stamp = 0;
    cur_valid = 0; cur_level = 0; cur_burst = 0; cur_run = 0; cur_rr = 0;
    r_l1_floor = 100; r_l2_floor = 50; r_threshold = 400;
    r_step = 10; r_cap = 149; r_quantum = 200;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset settings
    foreach (rows[k]) begin
      w.kind = rows[k].kind; w.id = rows[k].id; w.pri = rows[k].pri;
      w.burst = rows[k].burst; w.el = rows[k].el;
      repeat (rows[k].rep)
        send_word(w, rows[k].fixed, rows[k].exp_status, rows[k].exp_level);
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: write_regs(8'd100, 8'd50, 16'd400, 8'd10, 8'd149, 16'd200);
        1: write_regs(8'd149, 8'd0, 16'd0, 8'd149, 8'd0, 16'd0);
        2: write_regs(8'd0, 8'd149, 16'hFFFF, 8'd0, 8'd149, 16'hFFFF);
        default: write_regs(8'($urandom_range(149)), 8'($urandom_range(149)),
                            16'($urandom_range(2000)), 8'($urandom_range(149)),
                            8'($urandom_range(149)), 16'($urandom_range(3000)));
      endcase
      repeat (350) send_word(random_word(), 0, ST_OK, 2'd0);
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/tlq_pkg.sv
src/tlq_if.sv
src/tlq_ctrl.sv
src/tlq_dp.sv
src/three_level_ready_queue_scheduler.sv
bench/tb_three_level_ready_queue_scheduler.sv
